// ===== sv/deqs_pkg.sv =====
`default_nettype none
package deqs_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int MODE_W    = 3;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int POS_W     = 4;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SEARCH_BACK  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic                    found;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] removed_value;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic exec;
        logic pop_rd;
        logic scan;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic need_read;
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== sv/deqs_chan_if.sv =====
`default_nettype none
interface deqs_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/deqs_ram.sv =====
`default_nettype none
module deqs_ram #(
    parameter int W = 32,
    parameter int D = 16,
    localparam int AW = $clog2(D)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/deqs_ctrl.sv =====
`default_nettype none
module deqs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire deqs_pkg::t_sts i_sts,
    output deqs_pkg::t_cmd     o_cmd
);
    import deqs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_POP_RD = 5'b00100,
        S_SCAN   = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                priority if (i_sts.need_read) begin
                    n_state = S_POP_RD;
                end else if (i_sts.need_scan) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POP_RD: begin
                o_cmd.pop_rd = 1'b1;
                n_state      = S_FIN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.load = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/deqs_dp.sv =====
`default_nettype none
module deqs_dp #(
    parameter int DEPTH = deqs_pkg::DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire deqs_pkg::t_cmd                      i_cmd,
    output deqs_pkg::t_sts                           o_sts,
    input  wire logic [deqs_pkg::MODE_W-1:0]         i_mode,
    input  wire logic signed [deqs_pkg::VAL_W-1:0]   i_value,
    output deqs_pkg::t_out_item                      o_result,
    output logic                                     o_res_valid,
    input  wire logic                                i_res_ready
);
    import deqs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

    logic [AW-1:0]       r_head;
    logic [CW-1:0]       r_count;
    logic [MODE_W-1:0]   r_mode;
    logic [VAL_W-1:0]    r_key;
    logic [STAT_W-1:0]   r_status;
    logic                r_found;
    logic [POS_W-1:0]    r_pos;
    logic [VAL_W-1:0]    r_removed;
    logic [AW-1:0]       r_iss;
    logic [CW-1:0]       r_left;
    logic                r_pv;
    logic [AW-1:0]       r_poff;
    logic                r_ovalid;
    t_out_item           r_out;

    logic                is_pf, is_pb, is_popf, is_popb, is_sf, is_sb;
    logic                w_full, w_empty, w_push_ok, w_pop_ok, w_match;
    logic [AW-1:0]       w_off, w_slot, w_head_dec, w_head_inc;
    logic [AW:0]         w_sum;
    logic                w_we, w_re;
    logic [AW-1:0]       w_waddr, w_raddr;
    logic [VAL_W-1:0]    w_rdata;

    assign is_pf   = (r_mode == MODE_PUSH_FRONT);
    assign is_pb   = (r_mode == MODE_PUSH_BACK);
    assign is_popf = (r_mode == MODE_POP_FRONT);
    assign is_popb = (r_mode == MODE_POP_BACK);
    assign is_sf   = (r_mode == MODE_SEARCH_FRONT);
    assign is_sb   = (r_mode == MODE_SEARCH_BACK);

    assign w_full    = (r_count == DEPTH_C);
    assign w_empty   = (r_count == '0);
    assign w_push_ok = (is_pf || is_pb) && !w_full;
    assign w_pop_ok  = (is_popf || is_popb) && !w_empty;

    assign w_head_dec = (r_head == '0) ? LAST : r_head - 1'b1;
    assign w_head_inc = (r_head == LAST) ? '0 : r_head + 1'b1;

    always_comb begin
        priority if (i_cmd.scan) begin
            w_off = r_iss;
        end else if (is_pb) begin
            w_off = r_count[AW-1:0];
        end else begin
            w_off = AW'(r_count - 1'b1);
        end
    end

    assign w_sum  = {1'b0, r_head} + {1'b0, w_off};
    assign w_slot = (w_sum >= DEPTH_S) ? AW'(w_sum - DEPTH_S) : w_sum[AW-1:0];

    assign w_we    = i_cmd.exec && w_push_ok;
    assign w_waddr = is_pf ? w_head_dec : w_slot;
    assign w_re    = (i_cmd.exec && w_pop_ok) || (i_cmd.scan && (r_left != '0));
    assign w_raddr = (!i_cmd.scan && is_popf) ? r_head : w_slot;

    deqs_ram #(
        .W (VAL_W),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_key),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_match = r_pv && (w_rdata == r_key);

    assign o_sts.need_read = w_pop_ok;
    assign o_sts.need_scan = (is_sf || is_sb) && !w_empty;
    assign o_sts.scan_done = w_match || ((r_left == '0) && !r_pv);
    assign o_sts.out_free  = !r_ovalid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.exec && w_push_ok) begin
                r_count <= r_count + 1'b1;
                if (is_pf) begin
                    r_head <= w_head_dec;
                end
            end
            if (i_cmd.exec && w_pop_ok) begin
                r_count <= r_count - 1'b1;
                if (is_popf) begin
                    r_head <= w_head_inc;
                end
            end
            if (i_cmd.load) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_key  <= i_value;
        end
        if (i_cmd.exec) begin
            r_found   <= 1'b0;
            r_pos     <= '0;
            r_removed <= '0;
            r_pv      <= 1'b0;
            r_left    <= r_count;
            r_iss     <= is_sb ? AW'(r_count - 1'b1) : '0;
            priority if ((is_pf || is_pb) && w_full) begin
                r_status <= ST_FULL;
            end else if ((is_popf || is_popb) && w_empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end
        if (i_cmd.pop_rd) begin
            r_removed <= w_rdata;
        end
        if (i_cmd.scan) begin
            r_pv   <= (r_left != '0);
            r_poff <= r_iss;
            if (r_left != '0) begin
                r_left <= r_left - 1'b1;
                r_iss  <= is_sb ? r_iss - 1'b1 : r_iss + 1'b1;
            end
            if (w_match) begin
                r_found <= 1'b1;
                r_pos   <= POS_W'(r_poff);
            end
        end
        if (i_cmd.load) begin
            r_out.status        <= r_status;
            r_out.found         <= r_found;
            r_out.position      <= r_pos;
            r_out.removed_value <= r_removed;
        end
    end

    assign o_result    = r_out;
    assign o_res_valid = r_ovalid;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count exceeds depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST)
        else $error("head index out of range");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_push_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow the queue");

    a_scan_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_left <= r_count))
        else $error("scan walks past occupied entries");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_ovalid || i_res_ready))
        else $error("result overwritten before it was taken");

endmodule
`default_nettype wire

// ===== sv/double_ended_queue_with_search.sv =====
// Flow: accept, then execute; a pop adds a read of the removed entry and a search
// on a non-empty queue adds a scan, ended early at the first match; last, the result
// is loaded once the output is free. A new item is taken only after that load, so a
// result that waits for ready holds the input; a search walks one entry per cycle.
// Reset (synchronous, active low) empties the queue and zeroes the head;
// store contents stay undefined and need no clearing pass.
`default_nettype none
module double_ended_queue_with_search #(
    parameter int DEPTH = deqs_pkg::DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    deqs_chan_if.sink   i_in,
    deqs_chan_if.source o_out
);
    import deqs_pkg::*;

    t_cmd      w_cmd;
    t_sts      w_sts;
    t_in_item  w_in;
    t_out_item w_res;
    logic      w_in_ready;
    logic      w_res_valid;

    assign w_in       = i_in.data;
    assign i_in.ready = w_in_ready;
    assign o_out.valid = w_res_valid;
    assign o_out.data  = w_res;

    deqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    deqs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_mode      (w_in.mode),
        .i_value     (w_in.value),
        .o_result    (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_out.ready)
    );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import deqs_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int RAND_ITEMS  = 1550;
    localparam int CYCLE_LIMIT = 400000;
    localparam int CALM_FROM   = 3000;
    localparam int CALM_TO     = 6000;
    localparam int DRAIN_WAIT  = 40;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    deqs_chan_if #(.T(t_in_item))  in_ch ();
    deqs_chan_if #(.T(t_out_item)) out_ch ();

    double_ended_queue_with_search #(.DEPTH(DEPTH)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    t_out_item got_result;
    t_out_item want_result;

    logic signed [VAL_W-1:0] ring_mem [DEPTH];
    int ring_head;
    int ring_fill;

    int cycle_count;
    int mismatch_count;
    int result_count;

    logic signed [VAL_W-1:0] key_pool [8] = '{
        32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff,
        32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_0001, 32'sh0000_002a
    };

    function automatic logic idle_now();
        if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 18;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7) begin
            return key_pool[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    function automatic t_out_item deque_apply(t_in_item it);
        t_out_item res;
        int slot;
        res = '0;
        case (it.mode)
            MODE_PUSH_FRONT: begin
                if (ring_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_mem[ring_head] = it.value;
                    ring_fill++;
                end
            end
            MODE_PUSH_BACK: begin
                if (ring_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    ring_mem[(ring_head + ring_fill) % DEPTH] = it.value;
                    ring_fill++;
                end
            end
            MODE_POP_FRONT: begin
                if (ring_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.removed_value = ring_mem[ring_head];
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_fill--;
                end
            end
            MODE_POP_BACK: begin
                if (ring_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.removed_value = ring_mem[(ring_head + ring_fill - 1) % DEPTH];
                    ring_fill--;
                end
            end
            MODE_SEARCH_FRONT: begin
                for (int i = 0; i < ring_fill; i++) begin
                    slot = (ring_head + i) % DEPTH;
                    if (!res.found && ring_mem[slot] == it.value) begin
                        res.found = 1'b1;
                        res.position = i[POS_W-1:0];
                    end
                end
            end
            MODE_SEARCH_BACK: begin
                for (int i = ring_fill - 1; i >= 0; i--) begin
                    slot = (ring_head + i) % DEPTH;
                    if (!res.found && ring_mem[slot] == it.value) begin
                        res.found = 1'b1;
                        res.position = i[POS_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic add_item(logic [MODE_W-1:0] mode, logic signed [VAL_W-1:0] value);
        t_in_item it;
        it.mode = mode;
        it.value = value;
        pending_items.push_back(it);
    endtask

    task automatic note_mismatch(t_out_item want, t_out_item got, logic orphan);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (orphan) begin
                $display("result %0d with none expected: status=%0d found=%0d pos=%0d removed=%0d",
                         result_count, got.status, got.found, got.position, got.removed_value);
            end else begin
                $display("result %0d mismatch: exp status=%0d found=%0d pos=%0d removed=%0d",
                         result_count, want.status, want.found, want.position,
                         want.removed_value);
                $display("    got status=%0d found=%0d pos=%0d removed=%0d",
                         got.status, got.found, got.position, got.removed_value);
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** double_ended_queue_with_search: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(deque_apply(in_ch.data));
            end
            if (pending_items.size() != 0 && !idle_now()) begin
                in_ch.valid <= 1'b1;
                in_ch.data <= pending_items.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got_result = out_ch.data;
                result_count++;
                if (expected_results.size() == 0) begin
                    note_mismatch('0, got_result, 1'b1);
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result.status !== want_result.status ||
                        got_result.found !== want_result.found ||
                        got_result.position !== want_result.position ||
                        got_result.removed_value !== want_result.removed_value) begin
                        note_mismatch(want_result, got_result, 1'b0);
                    end
                end
            end
            out_ch.ready <= !idle_now();
        end
    end

    initial begin
        int bias_left;
        logic push_heavy;
        int roll;
        logic at_back;

        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        result_count = 0;
        ring_head = 0;
        ring_fill = 0;

        add_item(MODE_POP_FRONT, 32'sh1234_5678);
        add_item(MODE_POP_BACK, 32'sh0);
        add_item(MODE_SEARCH_FRONT, 32'sh0);
        add_item(MODE_SEARCH_BACK, 32'shffff_ffff);
        add_item(MODE_SPARE_LO, 32'shffff_ffff);
        add_item(MODE_SPARE_HI, 32'sh8000_0000);
        for (int i = 0; i < DEPTH; i++) begin
            add_item(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
                     (i % 4 == 1) ? 32'sh0000_002a : key_pool[i % 8]);
        end
        add_item(MODE_PUSH_FRONT, 32'sh7fff_ffff);
        add_item(MODE_PUSH_BACK, 32'sh8000_0000);
        add_item(MODE_SEARCH_FRONT, 32'sh0000_002a);
        add_item(MODE_SEARCH_BACK, 32'sh0000_002a);
        add_item(MODE_SEARCH_FRONT, 32'sh0bad_cafe);
        add_item(MODE_POP_FRONT, 32'sh0);
        add_item(MODE_POP_BACK, 32'shffff_ffff);

        bias_left = 0;
        push_heavy = 1'b1;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (bias_left == 0) begin
                bias_left = $urandom_range(10, 60);
                push_heavy = $urandom_range(0, 1);
            end
            bias_left--;
            roll = $urandom_range(0, 99);
            at_back = $urandom_range(0, 1);
            if (roll < 2) begin
                add_item(at_back ? MODE_SPARE_HI : MODE_SPARE_LO, $urandom);
            end else if (roll < (push_heavy ? 60 : 22)) begin
                add_item(at_back ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_value());
            end else if (roll < 80) begin
                add_item(at_back ? MODE_POP_BACK : MODE_POP_FRONT, $urandom);
            end else begin
                add_item(at_back ? MODE_SEARCH_BACK : MODE_SEARCH_FRONT, pick_value());
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("** double_ended_queue_with_search: PASSED **");
        end else begin
            $display("** double_ended_queue_with_search: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
